FILE: rtl/plc_pkg.sv
`timescale 1ns / 1ps

package plc_pkg;

    // Tree geometry
    localparam int TREE_LEVELS = 6;
    localparam int MAX_LENGTH  = 64;
    localparam int LEAVES      = 1 << TREE_LEVELS;
    localparam int NODES       = 1 << (TREE_LEVELS + 1);
    localparam int NODE_W      = TREE_LEVELS + 1;
    localparam int CNT_W       = TREE_LEVELS + 1;
    localparam int LVL_W       = $clog2(TREE_LEVELS + 1);

    // Field widths
    localparam int ELEM_W      = 6;
    localparam int LEN_W       = 7;
    localparam int LEN_MIN     = 2;
    localparam int LEN_CAP     = (MAX_LENGTH < LEAVES) ? MAX_LENGTH : LEAVES;

    // Stream and configuration port widths
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERM_LENGTH = CFG_IDX_W'(1);

    // Direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef struct packed {
        logic             start;
        logic             step;
        logic             leaf;
        logic             finish;
        logic [LVL_W-1:0] level;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_done;
        logic to_leaf;
    } t_dp_status;

    // Clamp the programmed length to the supported range
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        res = len;
        if (len < LEN_W'(LEN_MIN)) begin
            res = LEN_W'(LEN_MIN);
        end else if (len > LEN_W'(LEN_CAP)) begin
            res = LEN_W'(LEN_CAP);
        end
        return res;
    endfunction

    // Count held by a node right after re-initialization: zero when encoding,
    // the number of leaves below the node that lie under len when decoding.
    function automatic logic [CNT_W-1:0] init_count(input logic             dir,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] sh;
        logic [CNT_W-1:0]  span;
        logic [LEN_W-1:0]  start;
        logic [LEN_W-1:0]  rem;
        logic [CNT_W-1:0]  cnt;
        sh   = node;
        span = CNT_W'(1);
        for (int s = 0; s < TREE_LEVELS; s++) begin
            if (!sh[NODE_W-1]) begin
                sh   = {sh[NODE_W-2:0], 1'b0};
                span = {span[CNT_W-2:0], 1'b0};
            end
        end
        start = LEN_W'(sh[TREE_LEVELS-1:0]);
        rem   = len - start;
        if (dir == DIR_ENCODE || len <= start) begin
            cnt = '0;
        end else if (rem < LEN_W'(span)) begin
            cnt = CNT_W'(rem);
        end else begin
            cnt = span;
        end
        return cnt;
    endfunction

endpackage

FILE: rtl/plc_ram.sv
`timescale 1ns / 1ps

module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

FILE: rtl/plc_ctrl.sv
`timescale 1ns / 1ps

module plc_ctrl
    import plc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_LEAF,
        ST_FINISH
    } t_state;

    t_state           r_state;
    logic [LVL_W-1:0] r_level;
    logic             r_out_valid;
    logic             in_accept;
    logic             finish;

    // A pending register write goes first and holds off the input
    assign in_accept   = i_in_valid && (r_state == ST_IDLE) && !i_cfg_valid;
    assign finish      = (r_state == ST_FINISH) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.start  = in_accept;
        o_cmd.step   = (r_state == ST_WALK);
        o_cmd.leaf   = (r_state == ST_LEAF);
        o_cmd.finish = finish;
        o_cmd.level  = r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_WALK;
                        r_level <= '0;
                    end
                end
                ST_WALK: begin
                    if (i_status.walk_done) begin
                        r_state <= i_status.to_leaf ? ST_LEAF : ST_FINISH;
                    end else begin
                        r_level <= r_level + LVL_W'(1);
                    end
                end
                ST_LEAF: begin
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Output register: load on finish, drop on transfer
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/plc_datapath.sv
`timescale 1ns / 1ps

module plc_datapath
    import plc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [ELEM_W-1:0]     i_in_element,
    input  logic                  i_cfg_wr,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [ELEM_W-1:0]     o_out_value,
    output logic [ELEM_W-1:0]     o_out_position,
    output logic                  o_out_last,
    output logic                  o_out_error
);

    logic              r_dir;
    logic [LEN_W-1:0]  r_len;
    logic [ELEM_W-1:0] r_index;
    logic [NODES-1:0]  r_valid;
    logic [ELEM_W-1:0] r_elem;
    logic [ELEM_W-1:0] r_result;
    logic              r_err;
    logic [NODE_W-1:0] r_node;
    logic [NODE_W-1:0] r_addr_b;
    logic              r_vld_a;
    logic              r_vld_b;
    logic [ELEM_W-1:0] r_out_value;
    logic [ELEM_W-1:0] r_out_pos;
    logic              r_out_last;
    logic              r_out_err;

    logic [ELEM_W-1:0] n_elem;
    logic [ELEM_W-1:0] n_result;
    logic [NODE_W-1:0] n_node;

    logic [LEN_W-1:0]  len_eff;
    logic [CNT_W-1:0]  rd_a;
    logic [CNT_W-1:0]  rd_b;
    logic [CNT_W-1:0]  cnt_a;
    logic [CNT_W-1:0]  cnt_b;
    logic [NODE_W-1:0] addr_a;
    logic [NODE_W-1:0] addr_b;
    logic [NODE_W-1:0] left;
    logic              wr_en;
    logic [CNT_W-1:0]  wr_data;
    logic              step_err;
    logic              walk_done;
    logic              to_leaf;
    logic              last_item;
    logic              cfg_known;

    assign len_eff   = eff_len(r_len);
    assign cnt_a     = r_vld_a ? rd_a : init_count(r_dir, len_eff, r_node);
    assign cnt_b     = r_vld_b ? rd_b : init_count(r_dir, len_eff, r_addr_b);
    assign left      = {r_node[NODE_W-2:0], 1'b0};
    assign last_item = (LEN_W'(r_index) + LEN_W'(1)) >= len_eff;
    assign cfg_known = i_cfg_wr &&
                       (i_cfg_index == REG_DIRECTION || i_cfg_index == REG_PERM_LENGTH);

    always_comb begin
        n_node    = r_node;
        n_elem    = r_elem;
        n_result  = r_result;
        wr_en     = 1'b0;
        wr_data   = cnt_a;
        step_err  = 1'b0;
        walk_done = 1'b0;
        to_leaf   = 1'b0;
        if (i_cmd.start) begin
            n_elem   = i_in_element;
            n_result = i_in_element;
            n_node   = (r_dir == DIR_ENCODE) ? NODE_W'(LEAVES) + NODE_W'(i_in_element)
                                             : NODE_W'(1);
        end else if (i_cmd.step) begin
            if (r_dir == DIR_ENCODE) begin
                // Climb from the leaf, count earlier values to the left
                if (i_cmd.level == '0 &&
                    (LEN_W'(r_elem) >= len_eff || cnt_a != '0)) begin
                    step_err = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = cnt_a + CNT_W'(1);
                    if (r_node[0] && r_node != NODE_W'(1)) begin
                        n_result = r_result - cnt_b[ELEM_W-1:0];
                    end
                    n_node = r_node >> 1;
                end
                walk_done = step_err || (i_cmd.level == LVL_W'(TREE_LEVELS));
            end else begin
                // Descend by left-subtree counts, take one from each node
                if (i_cmd.level == '0 && CNT_W'(r_elem) >= cnt_a) begin
                    step_err = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = cnt_a - CNT_W'(1);
                    if (CNT_W'(r_elem) >= cnt_b) begin
                        n_elem = r_elem - cnt_b[ELEM_W-1:0];
                        n_node = left | NODE_W'(1);
                    end else begin
                        n_node = left;
                    end
                end
                walk_done = step_err || (i_cmd.level == LVL_W'(TREE_LEVELS - 1));
                to_leaf   = !step_err;
            end
        end else if (i_cmd.leaf) begin
            wr_en    = 1'b1;
            wr_data  = '0;
            n_result = r_node[ELEM_W-1:0];
        end
    end

    assign addr_a = n_node;
    assign addr_b = (r_dir == DIR_DECODE) ? {n_node[NODE_W-2:0], 1'b0}
                                          : n_node ^ NODE_W'(1);

    always_comb begin
        o_status.walk_done = walk_done;
        o_status.to_leaf   = to_leaf;
    end

    plc_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NODES)
    ) u_tree_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (r_node),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (addr_a),
        .i_rd_addr_b (addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_len   <= LEN_W'(MAX_LENGTH);
            r_index <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_wr && i_cfg_index == REG_DIRECTION) begin
                r_dir <= i_cfg_data[0];
            end
            if (i_cfg_wr && i_cfg_index == REG_PERM_LENGTH) begin
                r_len <= i_cfg_data[LEN_W-1:0];
            end
            if (cfg_known || (i_cmd.finish && !r_err && last_item)) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[r_node] <= 1'b1;
            end
            if (cfg_known) begin
                r_index <= '0;
            end else if (i_cmd.finish && !r_err) begin
                r_index <= last_item ? '0 : r_index + ELEM_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_elem   <= n_elem;
        r_result <= n_result;
        r_addr_b <= addr_b;
        r_vld_a  <= r_valid[addr_a];
        r_vld_b  <= r_valid[addr_b];
        if (i_cmd.start) begin
            r_err <= 1'b0;
        end else if (step_err) begin
            r_err <= 1'b1;
        end
        if (i_cmd.finish) begin
            r_out_value <= r_err ? '0 : r_result;
            r_out_pos   <= r_index;
            r_out_last  <= !r_err && last_item;
            r_out_err   <= r_err;
        end
    end

    assign o_out_value    = r_out_value;
    assign o_out_position = r_out_pos;
    assign o_out_last     = r_out_last;
    assign o_out_error    = r_out_err;

endmodule

FILE: rtl/permutation_lehmer_converter.sv
`timescale 1ns / 1ps

// Permutation <-> Lehmer digit converter, one element per stream transfer.
// Direction 0 takes permutation values and returns each value's Lehmer digit;
// direction 1 takes Lehmer digits and returns the permutation values. A counting
// tree of 2^TREE_LEVELS leaves lives in a two-read, one-write RAM; per-node
// valid flops let the whole tree snap back to its start state at once
// (empty for encode, leaves below the length marked for decode), so there is
// no clearing pass. Each item runs through its accept, TREE_LEVELS + 1 node
// rewrites through the single RAM write port and the result load, and no new
// item is taken before its result is loaded. A rejected item (repeated or
// out-of-range value, or a digit beyond the remaining count) ends after its
// first tree read, skipping the rewrites, with tuser set, zero value and state
// unchanged. Results sit in an output register, so a finished item does not
// block the walk of the next one until that one needs the register. Writing
// direction or perm_length restarts the permutation; write them only while
// idle. A pending register write takes priority and holds off the input.

module permutation_lehmer_converter
    import plc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [5:0] element, [7:6] unused
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [5:0] out_value, [11:6] position, [15:12] zero
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser   // [0] error
);

    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;
    logic              cfg_wr;
    logic [ELEM_W-1:0] out_value;
    logic [ELEM_W-1:0] out_position;

    // Config transfer completes only while the controller is idle
    assign cfg_wr = i_cfg_valid && o_cfg_ready;

    plc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    plc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_in_element   (s_axis_tdata[ELEM_W-1:0]),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_value    (out_value),
        .o_out_position (out_position),
        .o_out_last     (m_axis_tlast),
        .o_out_error    (m_axis_tuser)
    );

    // Pack the result word, zero fill to whole bytes
    assign m_axis_tdata = {{(M_TDATA_W - 2 * ELEM_W){1'b0}}, out_position, out_value};

`ifndef SYNTHESIS
    // A rejected item never closes a permutation and carries zero data
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && out_value == '0)
        else $error("rejected item shows last or nonzero value");

    // One item at a time: no new accept right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a walk is in progress");

    // A walk starts on the cycle after its accept
    a_walk_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.start |=> dp_cmd.step)
        else $error("tree walk did not start after accept");

    // Result register is loaded only when empty or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.finish |-> !m_axis_tvalid || m_axis_tready)
        else $error("pending result overwritten");
`endif

endmodule
